>>> hw/rtl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants of the log subscriber table
// Slot geometry, result kinds, command codes and the slot entry layout.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int NSTREAM     = 6;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] CODE_BREAK = 3'd0;
  localparam logic [2:0] CODE_FIRST = 3'd1;
  localparam logic [2:0] CODE_LAST  = 3'd6;

  localparam logic ACT_CMD = 1'b0;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_FWD    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [NSTREAM-1:0] flags;
    logic [15:0]        port;
    logic [31:0]        ip;
  } lst_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    lst_entry_t       data;
  } lst_mem_wr_t;

  typedef struct packed {
    logic [NSTREAM-1:0] inc;
    logic [NSTREAM-1:0] dec;
  } lst_cnt_upd_t;

  // one-hot stream flag for a stream code, zero for break and code seven
  function automatic logic [NSTREAM-1:0] stream_bit(input logic [2:0] code);
    logic [NSTREAM-1:0] b;
    b = '0;
    if (code >= CODE_FIRST && code <= CODE_LAST) begin
      b = NSTREAM'(1) << (code - CODE_FIRST);
    end
    return b;
  endfunction

endpackage

>>> hw/rtl/log_subscriber_table_top.sv
// ----------------------------------------------------------------------------
// log_subscriber_table_top: subscriber table for six log streams
// Input channel s_axis carries subscription commands and log items; output
// channel m_axis carries status, table-full and forward results.
// Usage:
//   One item is worked on at a time; s_axis_tready is high only while idle.
//   A command scans the slot memory (registered read) one slot per cycle
//   until the requester matches or the last slot is checked, then updates
//   and answers with one status or table-full result.
//   A log item scans every slot once, one slot per cycle while the output
//   does not stall, and emits one forward per subscriber, tlast on the
//   final one. The slot memory read port sets this rate.
//   A log item for code zero or seven produces nothing; the block stays idle.
//   Results pass through an output register; while m_axis_tready is low the
//   scan holds at the next forward and resumes without loss.
//   Reset clears all slot valid bits and stream counters at once; the block
//   is idle and ready to accept items as soon as reset is released.
// ----------------------------------------------------------------------------
module log_subscriber_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // requester_ip[31:0], requester_port[47:32], code[50:48]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // entry_flags[5:0], dest_ip[37:6], dest_port[53:38],
                                     // stream_enable[59:54]
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  localparam int IW = lst_pkg::IDX_W;
  localparam int CW = lst_pkg::CNT_W;
  localparam int RW = lst_pkg::RES_W;
  localparam int NS = lst_pkg::NSTREAM;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_RESP  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;

  // input decode
  logic        in_acc;
  logic        in_act;
  logic [31:0] in_ip;
  logic [15:0] in_port;
  logic [2:0]  in_code;

  assign in_act  = s_axis_tuser;
  assign in_ip   = s_axis_tdata[31:0];
  assign in_port = s_axis_tdata[47:32];
  assign in_code = s_axis_tdata[50:48];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // latched item
  logic          act_q;
  logic [31:0]   ip_q;
  logic [15:0]   port_q;
  logic [2:0]    code_q;
  logic [NS-1:0] bit_q;

  // scan pipeline
  logic [CW-1:0] ic_q, ic_d;
  logic          rd_vld_q, rd_vld_d;
  logic [IW-1:0] chk_q, chk_d;
  logic          rd_en;
  lst_pkg::lst_entry_t rd_ent;

  // command bookkeeping
  logic          hit_q, hit_d;
  logic [IW-1:0] hidx_q, hidx_d;
  logic [NS-1:0] old_q, old_d;
  logic          free_vld_q, free_vld_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  lst_pkg::kind_e res_kind_q, res_kind_d;
  logic [NS-1:0]  res_flags_q, res_flags_d;

  // forward bookkeeping
  logic                pend_vld_q, pend_vld_d;
  lst_pkg::lst_entry_t pend_q, pend_d;
  logic [RW-1:0]       fcnt_q, fcnt_d;

  logic [lst_pkg::SLOTS-1:0] valid_q, valid_d;

  lst_pkg::lst_mem_wr_t  mem_wr;
  lst_pkg::lst_cnt_upd_t cnt_upd;
  logic [NS-1:0]         stream_en;

  // output register
  logic           out_vld_q;
  lst_pkg::kind_e out_kind_q, out_kind_d;
  logic [NS-1:0]  out_flags_q, out_flags_d;
  logic [31:0]    out_ip_q, out_ip_d;
  logic [15:0]    out_port_q, out_port_d;
  logic [NS-1:0]  out_en_q;
  logic           out_last_q, out_last_d;
  logic           out_load;
  logic           out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  logic last_chk, cmd_match, log_match, stall;
  logic [NS-1:0] new_flags;

  assign last_chk  = (chk_q == IW'(lst_pkg::SLOTS - 1));
  assign cmd_match = rd_vld_q && valid_q[chk_q] && (rd_ent.ip == ip_q) &&
                     (rd_ent.port == port_q);
  assign log_match = rd_vld_q && valid_q[chk_q] && ((rd_ent.flags & bit_q) != '0);
  assign stall     = act_q && log_match && pend_vld_q && !out_free;
  assign new_flags = old_q ^ bit_q;

  always_comb begin
    state_d     = state_q;
    ic_d        = ic_q;
    rd_vld_d    = rd_vld_q;
    chk_d       = chk_q;
    rd_en       = 1'b0;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    old_d       = old_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    res_kind_d  = res_kind_q;
    res_flags_d = res_flags_q;
    pend_vld_d  = pend_vld_q;
    pend_d      = pend_q;
    fcnt_d      = fcnt_q;
    valid_d     = valid_q;
    mem_wr      = '0;
    cnt_upd     = '0;
    out_load    = 1'b0;
    out_kind_d  = lst_pkg::KIND_FWD;
    out_flags_d = pend_q.flags;
    out_ip_d    = pend_q.ip;
    out_port_d  = pend_q.port;
    out_last_d  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ic_d       = '0;
          rd_vld_d   = 1'b0;
          hit_d      = 1'b0;
          free_vld_d = 1'b0;
          pend_vld_d = 1'b0;
          fcnt_d     = '0;
          if (!(in_act != lst_pkg::ACT_CMD && lst_pkg::stream_bit(in_code) == '0)) begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (ic_q < CW'(lst_pkg::SLOTS)) begin
            rd_en    = 1'b1;
            rd_vld_d = 1'b1;
            chk_d    = ic_q[IW-1:0];
            ic_d     = ic_q + CW'(1);
          end else begin
            rd_vld_d = 1'b0;
          end
          if (rd_vld_q) begin
            if (act_q == lst_pkg::ACT_CMD) begin
              if (cmd_match) begin
                hit_d   = 1'b1;
                hidx_d  = chk_q;
                old_d   = rd_ent.flags;
                state_d = S_UPD;
              end else begin
                if (!valid_q[chk_q] && !free_vld_q) begin
                  free_vld_d = 1'b1;
                  free_idx_d = chk_q;
                end
                if (last_chk) begin
                  state_d = S_UPD;
                end
              end
            end else begin
              if (log_match) begin
                // the held forward goes out once a later one is known
                if (pend_vld_q) begin
                  out_load = 1'b1;
                end
                pend_vld_d = 1'b1;
                pend_d     = rd_ent;
                fcnt_d     = fcnt_q + RW'(1);
                if (fcnt_q == RW'(lst_pkg::MAX_RESULTS - 1) || last_chk) begin
                  state_d = S_FLUSH;
                end
              end else if (last_chk) begin
                state_d = pend_vld_q ? S_FLUSH : S_IDLE;
              end
            end
          end
        end
      end

      S_UPD: begin
        res_kind_d  = lst_pkg::KIND_STATUS;
        res_flags_d = '0;
        if (hit_q) begin
          if (code_q == lst_pkg::CODE_BREAK) begin
            valid_d[hidx_q] = 1'b0;
            cnt_upd.dec     = old_q;
          end else if (bit_q != '0) begin
            mem_wr.en         = 1'b1;
            mem_wr.addr       = hidx_q;
            mem_wr.data.ip    = ip_q;
            mem_wr.data.port  = port_q;
            mem_wr.data.flags = new_flags;
            cnt_upd.inc       = bit_q & ~old_q;
            cnt_upd.dec       = bit_q & old_q;
            res_flags_d       = new_flags;
          end else begin
            res_flags_d = old_q;
          end
        end else if (free_vld_q) begin
          if (bit_q != '0) begin
            valid_d[free_idx_q] = 1'b1;
            mem_wr.en           = 1'b1;
            mem_wr.addr         = free_idx_q;
            mem_wr.data.ip      = ip_q;
            mem_wr.data.port    = port_q;
            mem_wr.data.flags   = bit_q;
            cnt_upd.inc         = bit_q;
            res_flags_d         = bit_q;
          end
        end else begin
          res_kind_d = lst_pkg::KIND_FULL;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        out_kind_d  = res_kind_q;
        out_flags_d = res_flags_q;
        out_ip_d    = ip_q;
        out_port_d  = port_q;
        out_last_d  = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_FLUSH: begin
        out_last_d = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  lst_slot_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (ic_q[IW-1:0]),
    .rd_data_o (rd_ent)
  );

  lst_stream_cnt u_cnt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (cnt_upd),
    .stream_en_o (stream_en)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      free_vld_q <= 1'b0;
      pend_vld_q <= 1'b0;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
      ic_q       <= '0;
      fcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= rd_vld_d;
      hit_q      <= hit_d;
      free_vld_q <= free_vld_d;
      pend_vld_q <= pend_vld_d;
      valid_q    <= valid_d;
      ic_q       <= ic_d;
      fcnt_q     <= fcnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= in_act;
      ip_q   <= in_ip;
      port_q <= in_port;
      code_q <= in_code;
      bit_q  <= lst_pkg::stream_bit(in_code);
    end
    chk_q       <= chk_d;
    hidx_q      <= hidx_d;
    old_q       <= old_d;
    free_idx_q  <= free_idx_d;
    res_kind_q  <= res_kind_d;
    res_flags_q <= res_flags_d;
    pend_q      <= pend_d;
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_flags_q <= out_flags_d;
      out_ip_q    <= out_ip_d;
      out_port_q  <= out_port_d;
      out_en_q    <= stream_en;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, out_en_q, out_port_q, out_ip_q, out_flags_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // a flush always has a held forward to send
  a_flush_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |-> pend_vld_q)
    else $error("flush without held forward");

  // forward count never passes the result limit
  a_fcnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= RW'(lst_pkg::MAX_RESULTS))
    else $error("forward count beyond limit");

  // status and table-full results are always the only result of their item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != lst_pkg::KIND_FWD) |-> m_axis_tlast)
    else $error("status result without tlast");

  // log item for a code that names no stream leaves the block idle
  a_nostream_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_act != lst_pkg::ACT_CMD && lst_pkg::stream_bit(in_code) == '0)
    |=> state_q == S_IDLE)
    else $error("log item without stream started a scan");

endmodule

>>> hw/rtl/lst_slot_mem.sv
// ----------------------------------------------------------------------------
// lst_slot_mem: slot storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lst_slot_mem (
  input  logic                     clk_i,
  input  lst_pkg::lst_mem_wr_t     wr_i,
  input  logic                     rd_en_i,
  input  logic [lst_pkg::IDX_W-1:0] rd_addr_i,
  output lst_pkg::lst_entry_t      rd_data_o
);

  lst_pkg::lst_entry_t mem [lst_pkg::SLOTS];
  lst_pkg::lst_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/lst_stream_cnt.sv
// ----------------------------------------------------------------------------
// lst_stream_cnt: per-stream subscriber counters
// Counts valid slots holding each stream flag; a stream is enabled while
// its count is nonzero.
// ----------------------------------------------------------------------------
module lst_stream_cnt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lst_pkg::lst_cnt_upd_t        upd_i,
  output logic [lst_pkg::NSTREAM-1:0]  stream_en_o
);

  logic [lst_pkg::CNT_W-1:0] cnt_q [lst_pkg::NSTREAM];
  logic [lst_pkg::CNT_W-1:0] cnt_d [lst_pkg::NSTREAM];

  always_comb begin
    for (int b = 0; b < lst_pkg::NSTREAM; b++) begin
      cnt_d[b] = cnt_q[b];
      if (upd_i.inc[b]) begin
        cnt_d[b] = cnt_q[b] + lst_pkg::CNT_W'(1);
      end else if (upd_i.dec[b]) begin
        cnt_d[b] = cnt_q[b] - lst_pkg::CNT_W'(1);
      end
      stream_en_o[b] = (cnt_q[b] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < lst_pkg::NSTREAM; b++) begin
        cnt_q[b] <= '0;
      end
    end else begin
      for (int b = 0; b < lst_pkg::NSTREAM; b++) begin
        cnt_q[b] <= cnt_d[b];
      end
    end
  end

endmodule
